[sv/rfpc_pkg.sv]
// Package for the register file and PC sequencer: transfer payload types,
// command codes and register numbers. No dependencies.
`default_nettype none

package rfpc_pkg;

    localparam int unsigned NUM_REGS = 16;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned IDX_W    = $clog2(NUM_REGS);

    localparam logic [3:0] CMD_READ     = 4'd0;
    localparam logic [3:0] CMD_WRITE    = 4'd1;
    localparam logic [3:0] CMD_PC_WRITE = 4'd2;
    localparam logic [3:0] CMD_BRANCH   = 4'd3;
    localparam logic [3:0] CMD_MARK     = 4'd4;
    localparam logic [3:0] CMD_UPDATE   = 4'd5;
    localparam logic [3:0] CMD_CHECK    = 4'd6;
    localparam logic [3:0] CMD_FLAGS    = 4'd7;
    localparam logic [3:0] CMD_INIT     = 4'd8;

    localparam logic [IDX_W-1:0] SP_IDX = 4'd13;
    localparam logic [IDX_W-1:0] LR_IDX = 4'd14;
    localparam logic [IDX_W-1:0] PC_IDX = 4'd15;

    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_16   = 2'd1;
    localparam logic [1:0] SIZE_32   = 2'd2;

    localparam logic [DATA_W-1:0] ALIGN_MASK = 32'hffff_fffe;
    localparam logic [DATA_W-1:0] ALL_ONES   = 32'hffff_ffff;

    typedef struct packed {
        logic [3:0]        command;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] data_value;
        logic [DATA_W-1:0] reset_pc_word;
        logic [1:0]        inst_size;
        logic [3:0]        cond_code;
        logic [3:0]        nzcv_in;
    } rfpc_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              cond_pass;
    } rfpc_out_t;

endpackage

`default_nettype wire

[sv/cpu_register_file_pc_cond_top.sv]
// Register file, PC sequencer and condition check of a sixteen-register core.
// Depends on rfpc_pkg for payload types, command codes and register numbers.
//
//   Channel | Signals                          | Payload
//   --------+----------------------------------+----------------------
//   in      | in_valid, in_ready, in_data      | rfpc_pkg::rfpc_in_t
//   out     | out_valid, out_ready, out_data   | rfpc_pkg::rfpc_out_t
//
// One item is taken every cycle while the output is not stalled; each gives
// one result, registered in the input register and then the result register.
// All state is updated in the cycle an item leaves the input register.
// Reset clears the control flags, the flags register and the registers, with
// LR set to all ones. A stalled output holds the result and, once the input
// register is also full, stops taking input.
`default_nettype none

module cpu_register_file_pc_cond_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rfpc_pkg::rfpc_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rfpc_pkg::rfpc_out_t      out_data
);
    import rfpc_pkg::*;

    rfpc_in_t          s1_data_reg;
    logic              s1_valid_reg;
    logic              out_valid_reg;
    rfpc_out_t         out_data_reg;
    rfpc_out_t         result_next;

    logic [DATA_W-1:0] regs_reg [NUM_REGS];
    logic [DATA_W-1:0] regs_next [NUM_REGS];
    logic              branch_pending_reg, branch_pending_next;
    logic [DATA_W-1:0] branch_target_reg, branch_target_next;
    logic              pc_direct_reg, pc_direct_next;
    logic [3:0]        nzcv_reg, nzcv_next;

    logic              advance;
    logic [DATA_W-1:0] pc_step;

    function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
        logic n, z, c, v, r;
        n = f[3];
        z = f[2];
        c = f[1];
        v = f[0];
        case (cond)
            4'd0:    r = z;
            4'd1:    r = !z;
            4'd2:    r = c;
            4'd3:    r = !c;
            4'd4:    r = n;
            4'd5:    r = !n;
            4'd6:    r = v;
            4'd7:    r = !v;
            4'd8:    r = c && !z;
            4'd9:    r = !c || z;
            4'd10:   r = (n == v);
            4'd11:   r = (n != v);
            4'd12:   r = !z && (n == v);
            4'd13:   r = z || (n != v);
            4'd14:   r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // The input register moves on whenever the result register is free or
    // being emptied in this cycle.
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        case (s1_data_reg.inst_size)
            SIZE_16: pc_step = 32'd2;
            SIZE_32: pc_step = 32'd4;
            default: pc_step = '0;
        endcase
    end

    always_comb
    begin
        regs_next           = regs_reg;
        branch_pending_next = branch_pending_reg;
        branch_target_next  = branch_target_reg;
        pc_direct_next      = pc_direct_reg;
        nzcv_next           = nzcv_reg;
        result_next         = '0;

        case (s1_data_reg.command)
            CMD_READ:
            begin
                if (s1_data_reg.reg_index == PC_IDX)
                    result_next.read_data = regs_reg[PC_IDX] + 32'd4;
                else
                    result_next.read_data = regs_reg[s1_data_reg.reg_index];
            end
            CMD_WRITE:
                regs_next[s1_data_reg.reg_index] = s1_data_reg.data_value;
            CMD_PC_WRITE:
                regs_next[PC_IDX] = s1_data_reg.data_value & ALIGN_MASK;
            CMD_BRANCH:
            begin
                branch_pending_next = 1'b1;
                branch_target_next  = s1_data_reg.data_value;
            end
            CMD_MARK:
                pc_direct_next = 1'b1;
            CMD_UPDATE:
            begin
                // A pending branch wins over the direct-change mark, which
                // in turn suppresses the normal advance.
                if (branch_pending_reg)
                begin
                    regs_next[PC_IDX]   = branch_target_reg & ALIGN_MASK;
                    branch_pending_next = 1'b0;
                end
                else if (pc_direct_reg)
                begin
                    regs_next[PC_IDX] = regs_reg[PC_IDX] & ALIGN_MASK;
                    pc_direct_next    = 1'b0;
                end
                else
                begin
                    regs_next[PC_IDX] = (regs_reg[PC_IDX] + pc_step) & ALIGN_MASK;
                end
            end
            CMD_CHECK:
                result_next.cond_pass = cond_holds(s1_data_reg.cond_code, nzcv_reg);
            CMD_FLAGS:
                nzcv_next = s1_data_reg.nzcv_in;
            CMD_INIT:
            begin
                for (int i = 0; i < int'(SP_IDX); i++)
                    regs_next[i] = '0;
                regs_next[SP_IDX] = s1_data_reg.data_value;
                regs_next[LR_IDX] = ALL_ONES;
                regs_next[PC_IDX] = s1_data_reg.reset_pc_word & ALIGN_MASK;
                nzcv_next         = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
        if (advance && s1_valid_reg)
            out_data_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                regs_reg[i] <= '0;
            regs_reg[LR_IDX]   <= ALL_ONES;
            branch_pending_reg <= 1'b0;
            branch_target_reg  <= '0;
            pc_direct_reg      <= 1'b0;
            nzcv_reg           <= '0;
        end
        else if (advance && s1_valid_reg)
        begin
            regs_reg           <= regs_next;
            branch_pending_reg <= branch_pending_next;
            branch_target_reg  <= branch_target_next;
            pc_direct_reg      <= pc_direct_next;
            nzcv_reg           <= nzcv_next;
        end
    end

endmodule

`default_nettype wire

[sv/rfpc_checker.sv]
// Port-level checks for the register file top level, attached by bind.
// Depends on rfpc_pkg for the payload types.
`default_nettype none

module rfpc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire rfpc_pkg::rfpc_in_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire rfpc_pkg::rfpc_out_t out_data
);
    import rfpc_pkg::*;

    // A refused input stays offered with the same payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input withdrawn or changed while refused");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // With nothing waiting at the output, input is always taken.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output");

    // A result comes from a read or a condition check, never both.
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.cond_pass |-> out_data.read_data == '0)
        else $error("read data on a condition result");

endmodule

bind cpu_register_file_pc_cond_top rfpc_checker u_rfpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
